FILE: sv/spd_pkg.sv
// Shared types and constants of the slotted page directory.
`default_nettype none
package spd_pkg;
  localparam int CMD_W  = 3;
  localparam int SLOT_W = 6;
  localparam int BYTE_W = 13;
  localparam int LIVE_W = 7;
  localparam int STAT_W = 3;
  localparam int ACC_W  = 20;

  localparam int MAX_SLOTS_DEF  = 64;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int SLOT_BYTES_DEF = 4;

  localparam logic [BYTE_W-1:0] HDR_RESET = 13'd32;
  localparam logic [BYTE_W-1:0] BYTE_MAX  = 13'h1FFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_UPDATE  = 3'd3,
    CMD_GET     = 3'd4,
    CMD_COMPACT = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_RANGE   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_GAP,
    S_INS_NEED,
    S_INS_CHK,
    S_INS_OFF,
    S_INS_END,
    S_INS_BYTES,
    S_DEL_BYTES,
    S_UPD_CMP,
    S_UPD_CHK,
    S_UPD_SUB,
    S_UPD_OFF,
    S_UPD_ADD,
    S_CMP_TOT,
    S_SCAN,
    S_PICK,
    S_PICK2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              we_off;
    logic              we_len;
    logic [SLOT_W-1:0] waddr;
    logic [BYTE_W-1:0] woff;
    logic [BYTE_W-1:0] wlen;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] off;
    logic [BYTE_W-1:0] prev;
    logic [BYTE_W-1:0] len;
    logic              last;
  } res_t;
endpackage
`default_nettype wire

FILE: sv/spd_ifs.sv
// Channel interfaces: command input, result output, header size write.
`default_nettype none
interface spd_in_if;
  logic                       valid;
  logic                       ready;
  logic [spd_pkg::CMD_W-1:0]  cmd;
  logic [spd_pkg::SLOT_W-1:0] slot_index;
  logic [spd_pkg::BYTE_W-1:0] record_size;
  modport source (output valid, cmd, slot_index, record_size, input ready);
  modport sink (input valid, cmd, slot_index, record_size, output ready);
endinterface

interface spd_out_if;
  logic                       valid;
  logic                       ready;
  logic [spd_pkg::STAT_W-1:0] status;
  logic [spd_pkg::SLOT_W-1:0] slot_out;
  logic [spd_pkg::BYTE_W-1:0] rec_offset;
  logic [spd_pkg::BYTE_W-1:0] previous_offset;
  logic [spd_pkg::BYTE_W-1:0] record_length;
  logic [spd_pkg::BYTE_W-1:0] free_bytes;
  logic [spd_pkg::LIVE_W-1:0] live_records;
  logic                       last;
  modport source (output valid, status, slot_out, rec_offset, previous_offset,
                  record_length, free_bytes, live_records, last, input ready);
  modport sink (input valid, status, slot_out, rec_offset, previous_offset,
                record_length, free_bytes, live_records, last, output ready);
endinterface

interface spd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [spd_pkg::BYTE_W-1:0] header_size;
  modport source (output valid, header_size, input ready);
  modport sink (input valid, header_size, output ready);
endinterface
`default_nettype wire

FILE: sv/spd_alu.sv
// Shared add/subtract unit used by the arithmetic steps of the sequencer.
`default_nettype none
module spd_alu (
  input  var spd_pkg::alu_op_t           op,
  input  var logic [spd_pkg::ACC_W-1:0]  a,
  input  var logic [spd_pkg::ACC_W-1:0]  b,
  output var logic [spd_pkg::ACC_W-1:0]  res,
  output var logic                       neg
);
  import spd_pkg::*;

  logic [ACC_W:0] full;

  always_comb begin
    case (op)
      ALU_ADD: full = {1'b0, a} + {1'b0, b};
      ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default: full = '0;
    endcase
  end

  assign res = full[ACC_W-1:0];
  // borrow out of a subtract: a < b
  assign neg = (op == ALU_SUB) & full[ACC_W];
endmodule
`default_nettype wire

FILE: sv/spd_mem.sv
// Slot offset and length memories, one write and one registered read port.
`default_nettype none
module spd_mem #(
  parameter int DEPTH = spd_pkg::MAX_SLOTS_DEF
) (
  input  var logic                       clk,
  input  var spd_pkg::mem_req_t          req,
  output var logic [spd_pkg::BYTE_W-1:0] rd_off,
  output var logic [spd_pkg::BYTE_W-1:0] rd_len
);
  import spd_pkg::*;

  logic [BYTE_W-1:0] off_mem [DEPTH];
  logic [BYTE_W-1:0] len_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we_off) off_mem[req.waddr] <= req.woff;
    if (req.we_len) len_mem[req.waddr] <= req.wlen;
    rd_off <= off_mem[req.raddr];
    rd_len <= len_mem[req.raddr];
  end
endmodule
`default_nettype wire

FILE: sv/slotted_page_directory.sv
// Slot directory of one slotted page: command sequencer around a shared adder.
//
//  channel | dir | handshake   | payload
//  in_ch   | in  | valid/ready | cmd, slot_index, record_size
//  out_ch  | out | valid/ready | status .. last, one or more per command
//  cfg_ch  | in  | valid/ready | header_size
//
// Init, get, unknown commands and early rejects end at decode; delete adds a byte update,
// in-place update a length compare; inserts and relocating updates first check the gap.
// Every arithmetic step uses the one adder. Each compact move rescans the offset memory
// through its single read port to find the highest old offset.
// Reset clears all control state; no clearing pass. A stalled result holds the sequencer
// at its output register; input is taken only when the sequencer is idle.
`default_nettype none
module slotted_page_directory #(
  parameter int MAX_SLOTS  = spd_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BYTES = spd_pkg::PAGE_BYTES_DEF,
  parameter int SLOT_BYTES = spd_pkg::SLOT_BYTES_DEF
) (
  input var logic clk,
  input var logic rst_n,
  spd_in_if.sink    in_ch,
  spd_out_if.source out_ch,
  spd_cfg_if.sink   cfg_ch
);
  import spd_pkg::*;

  localparam logic [BYTE_W-1:0] PAGE = BYTE_W'(PAGE_BYTES);
  localparam logic [ACC_W-1:0]  SBYT = ACC_W'(SLOT_BYTES);
  localparam logic [LIVE_W-1:0] MAXS = LIVE_W'(MAX_SLOTS);

  state_t st_r, st_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [BYTE_W-1:0]    size_r, size_nxt;
  logic [BYTE_W-1:0]    hdr_r, hdr_nxt;
  logic [MAX_SLOTS-1:0] valid_r, valid_nxt;
  logic [MAX_SLOTS-1:0] done_r, done_nxt;
  logic [LIVE_W-1:0]    siu_r, siu_nxt;
  logic [LIVE_W-1:0]    live_r, live_nxt;
  logic [ACC_W-1:0]     lbytes_r, lbytes_nxt;
  logic [BYTE_W-1:0]    sae_r, sae_nxt;
  logic [BYTE_W-1:0]    ras_r, ras_nxt;
  logic [BYTE_W-1:0]    gap_r, gap_nxt;
  logic [ACC_W-1:0]     need_r, need_nxt;
  logic [SLOT_W-1:0]    s_r, s_nxt;
  logic                 app_r, app_nxt;
  res_t                 res_r, res_nxt;
  logic [BYTE_W-1:0]    wpos_r, wpos_nxt;
  logic [LIVE_W-1:0]    scan_r, scan_nxt;
  logic                 pend_r, pend_nxt;
  logic [SLOT_W-1:0]    pidx_r, pidx_nxt;
  logic                 bhave_r, bhave_nxt;
  logic [SLOT_W-1:0]    bslot_r, bslot_nxt;
  logic [BYTE_W-1:0]    boff_r, boff_nxt;
  logic [LIVE_W-1:0]    k_r, k_nxt;
  logic                 ovld_r, ovld_nxt;
  res_t                 ores_r, ores_nxt;
  logic [BYTE_W-1:0]    ofree_r, ofree_nxt;
  logic [LIVE_W-1:0]    olive_r, olive_nxt;

  mem_req_t          mreq;
  logic [BYTE_W-1:0] rd_off, rd_len;
  alu_op_t           alu_op;
  logic [ACC_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_neg;
  logic [LIVE_W-1:0] first_free;
  logic              reuse;
  logic              out_free;
  logic [BYTE_W-1:0] sat_diff;

  spd_mem #(.DEPTH(MAX_SLOTS)) u_mem (
    .clk    (clk),
    .req    (mreq),
    .rd_off (rd_off),
    .rd_len (rd_len)
  );

  spd_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .neg (alu_neg)
  );

  // lowest empty slot; slots at or above siu are never valid
  always_comb begin
    first_free = MAXS;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) first_free = LIVE_W'(i);
    end
  end
  assign reuse = first_free < siu_r;

  assign out_free = !ovld_r || out_ch.ready;
  assign sat_diff = alu_neg ? '0 : alu_res[BYTE_W-1:0];

  assign in_ch.ready  = rst_n && (st_r == S_IDLE);
  assign cfg_ch.ready = rst_n;

  assign out_ch.valid           = ovld_r;
  assign out_ch.status          = ores_r.status;
  assign out_ch.slot_out        = ores_r.slot;
  assign out_ch.rec_offset      = ores_r.off;
  assign out_ch.previous_offset = ores_r.prev;
  assign out_ch.record_length   = ores_r.len;
  assign out_ch.free_bytes      = ofree_r;
  assign out_ch.live_records    = olive_r;
  assign out_ch.last            = ores_r.last;

  always_comb begin
    st_nxt     = st_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    size_nxt   = size_r;
    hdr_nxt    = hdr_r;
    valid_nxt  = valid_r;
    done_nxt   = done_r;
    siu_nxt    = siu_r;
    live_nxt   = live_r;
    lbytes_nxt = lbytes_r;
    sae_nxt    = sae_r;
    ras_nxt    = ras_r;
    gap_nxt    = gap_r;
    need_nxt   = need_r;
    s_nxt      = s_r;
    app_nxt    = app_r;
    res_nxt    = res_r;
    wpos_nxt   = wpos_r;
    scan_nxt   = scan_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    bhave_nxt  = bhave_r;
    bslot_nxt  = bslot_r;
    boff_nxt   = boff_r;
    k_nxt      = k_r;
    ovld_nxt   = ovld_r && !out_ch.ready;
    ores_nxt   = ores_r;
    ofree_nxt  = ofree_r;
    olive_nxt  = olive_r;
    mreq       = '0;
    mreq.raddr = idx_r;
    alu_op     = ALU_SUB;
    alu_a      = '0;
    alu_b      = '0;

    if (cfg_ch.valid) hdr_nxt = cfg_ch.header_size;

    case (st_r)
      S_IDLE: begin
        mreq.raddr = in_ch.slot_index;
        if (in_ch.valid) begin
          cmd_nxt  = in_ch.cmd;
          idx_nxt  = in_ch.slot_index;
          size_nxt = in_ch.record_size;
          st_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        res_nxt = '{status: ST_OK, slot: '0, off: '0, prev: '0, len: '0, last: 1'b1};
        st_nxt  = S_EMIT;
        case (cmd_r)
          CMD_INIT: begin
            valid_nxt  = '0;
            siu_nxt    = '0;
            live_nxt   = '0;
            lbytes_nxt = '0;
            sae_nxt    = hdr_r;
            ras_nxt    = PAGE;
          end
          CMD_INSERT: begin
            if (size_r == '0) begin
              res_nxt.status = ST_ZERO;
            end else if (!reuse && siu_r >= MAXS) begin
              res_nxt.status = ST_NOSPACE;
            end else begin
              s_nxt   = reuse ? first_free[SLOT_W-1:0] : siu_r[SLOT_W-1:0];
              app_nxt = !reuse;
              st_nxt  = S_GAP;
            end
          end
          CMD_DELETE, CMD_UPDATE, CMD_GET: begin
            res_nxt.slot = idx_r;
            if (LIVE_W'(idx_r) >= siu_r) begin
              res_nxt.status = ST_RANGE;
            end else if (cmd_r == CMD_UPDATE && size_r == '0) begin
              res_nxt.status = ST_ZERO;
            end else if (!valid_r[idx_r]) begin
              res_nxt.status = ST_EMPTY;
            end else if (cmd_r == CMD_DELETE) begin
              valid_nxt[idx_r] = 1'b0;
              live_nxt         = live_r - 1'b1;
              st_nxt           = S_DEL_BYTES;
            end else if (cmd_r == CMD_GET) begin
              res_nxt.off  = rd_off;
              res_nxt.prev = rd_off;
              res_nxt.len  = rd_len;
            end else begin
              st_nxt = S_UPD_CMP;
            end
          end
          CMD_COMPACT: begin
            if (siu_r == '0) begin
              st_nxt = S_EMIT;
            end else if (live_r == '0) begin
              ras_nxt = PAGE;
            end else begin
              st_nxt = S_CMP_TOT;
            end
          end
          default: st_nxt = S_EMIT;
        endcase
      end

      S_GAP: begin
        alu_a   = ACC_W'(ras_r);
        alu_b   = ACC_W'(sae_r);
        gap_nxt = sat_diff;
        st_nxt  = (cmd_r == CMD_INSERT) ? S_INS_NEED : S_UPD_CHK;
      end

      S_INS_NEED: begin
        alu_op   = ALU_ADD;
        alu_a    = ACC_W'(size_r);
        alu_b    = app_r ? SBYT : '0;
        need_nxt = alu_res;
        st_nxt   = S_INS_CHK;
      end

      S_INS_CHK: begin
        alu_a = ACC_W'(gap_r);
        alu_b = need_r;
        if (alu_neg) begin
          res_nxt.status = ST_NOSPACE;
          st_nxt         = S_EMIT;
        end else begin
          st_nxt = S_INS_OFF;
        end
      end

      S_INS_OFF: begin
        alu_a       = ACC_W'(ras_r);
        alu_b       = ACC_W'(size_r);
        mreq.we_off = 1'b1;
        mreq.we_len = 1'b1;
        mreq.waddr  = s_r;
        mreq.woff   = alu_res[BYTE_W-1:0];
        mreq.wlen   = size_r;
        valid_nxt[s_r] = 1'b1;
        ras_nxt     = alu_res[BYTE_W-1:0];
        res_nxt.slot = s_r;
        res_nxt.off  = alu_res[BYTE_W-1:0];
        res_nxt.len  = size_r;
        st_nxt      = app_r ? S_INS_END : S_INS_BYTES;
      end

      // array end follows the current header size
      S_INS_END: begin
        alu_op  = ALU_ADD;
        alu_a   = ACC_W'(hdr_r);
        alu_b   = ACC_W'(siu_r) * SBYT + SBYT;
        sae_nxt = (alu_res > ACC_W'(BYTE_MAX)) ? BYTE_MAX : alu_res[BYTE_W-1:0];
        siu_nxt = siu_r + 1'b1;
        st_nxt  = S_INS_BYTES;
      end

      S_INS_BYTES: begin
        alu_op     = ALU_ADD;
        alu_a      = lbytes_r;
        alu_b      = ACC_W'(size_r);
        lbytes_nxt = alu_res;
        live_nxt   = live_r + 1'b1;
        st_nxt     = S_EMIT;
      end

      S_DEL_BYTES: begin
        alu_a      = lbytes_r;
        alu_b      = ACC_W'(rd_len);
        lbytes_nxt = alu_res;
        st_nxt     = S_EMIT;
      end

      S_UPD_CMP: begin
        alu_a = ACC_W'(rd_len);
        alu_b = ACC_W'(size_r);
        if (alu_neg) begin
          st_nxt = S_GAP;
        end else begin
          res_nxt.off  = rd_off;
          res_nxt.prev = rd_off;
          res_nxt.len  = rd_len;
          st_nxt       = S_EMIT;
        end
      end

      S_UPD_CHK: begin
        alu_a = ACC_W'(gap_r);
        alu_b = ACC_W'(size_r);
        if (alu_neg) begin
          res_nxt.status = ST_NOSPACE;
          st_nxt         = S_EMIT;
        end else begin
          st_nxt = S_UPD_SUB;
        end
      end

      // retire the old length before the memory is rewritten
      S_UPD_SUB: begin
        alu_a      = lbytes_r;
        alu_b      = ACC_W'(rd_len);
        lbytes_nxt = alu_res;
        st_nxt     = S_UPD_OFF;
      end

      S_UPD_OFF: begin
        alu_a        = ACC_W'(ras_r);
        alu_b        = ACC_W'(size_r);
        mreq.we_off  = 1'b1;
        mreq.we_len  = 1'b1;
        mreq.waddr   = idx_r;
        mreq.woff    = alu_res[BYTE_W-1:0];
        mreq.wlen    = size_r;
        ras_nxt      = alu_res[BYTE_W-1:0];
        res_nxt.off  = alu_res[BYTE_W-1:0];
        res_nxt.prev = rd_off;
        res_nxt.len  = size_r;
        st_nxt       = S_UPD_ADD;
      end

      S_UPD_ADD: begin
        alu_op     = ALU_ADD;
        alu_a      = lbytes_r;
        alu_b      = ACC_W'(size_r);
        lbytes_nxt = alu_res;
        st_nxt     = S_EMIT;
      end

      // final record area start is known up front from the live byte total
      S_CMP_TOT: begin
        alu_a     = ACC_W'(PAGE);
        alu_b     = lbytes_r;
        ras_nxt   = sat_diff;
        wpos_nxt  = PAGE;
        done_nxt  = '0;
        k_nxt     = '0;
        scan_nxt  = '0;
        pend_nxt  = 1'b0;
        bhave_nxt = 1'b0;
        st_nxt    = S_SCAN;
      end

      S_SCAN: begin
        if (scan_r < siu_r) begin
          mreq.raddr = scan_r[SLOT_W-1:0];
          scan_nxt   = scan_r + 1'b1;
          pend_nxt   = 1'b1;
          pidx_nxt   = scan_r[SLOT_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          alu_a = ACC_W'(boff_r);
          alu_b = ACC_W'(rd_off);
          // strict greater keeps the lower slot on equal offsets
          if (valid_r[pidx_r] && !done_r[pidx_r] && (!bhave_r || alu_neg)) begin
            bhave_nxt = 1'b1;
            bslot_nxt = pidx_r;
            boff_nxt  = rd_off;
          end
        end
        if (scan_r >= siu_r && !pend_r) st_nxt = S_PICK;
      end

      S_PICK: begin
        mreq.raddr = bslot_r;
        st_nxt     = S_PICK2;
      end

      S_PICK2: begin
        mreq.raddr  = bslot_r;
        alu_a       = ACC_W'(wpos_r);
        alu_b       = ACC_W'(rd_len);
        mreq.we_off = 1'b1;
        mreq.waddr  = bslot_r;
        mreq.woff   = sat_diff;
        wpos_nxt    = sat_diff;
        done_nxt[bslot_r] = 1'b1;
        k_nxt       = k_r + 1'b1;
        res_nxt = '{status: ST_OK, slot: bslot_r, off: sat_diff, prev: boff_r,
                    len: rd_len, last: (k_r + 1'b1 == live_r)};
        st_nxt      = S_EMIT;
      end

      S_EMIT: begin
        alu_a = ACC_W'(ras_r);
        alu_b = ACC_W'(sae_r);
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ores_nxt  = res_r;
          ofree_nxt = sat_diff;
          olive_nxt = live_r;
          if (res_r.last) begin
            st_nxt = S_IDLE;
          end else begin
            scan_nxt  = '0;
            pend_nxt  = 1'b0;
            bhave_nxt = 1'b0;
            st_nxt    = S_SCAN;
          end
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      hdr_r    <= HDR_RESET;
      valid_r  <= '0;
      done_r   <= '0;
      siu_r    <= '0;
      live_r   <= '0;
      lbytes_r <= '0;
      sae_r    <= HDR_RESET;
      ras_r    <= PAGE;
      ovld_r   <= 1'b0;
      pend_r   <= 1'b0;
      bhave_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      hdr_r    <= hdr_nxt;
      valid_r  <= valid_nxt;
      done_r   <= done_nxt;
      siu_r    <= siu_nxt;
      live_r   <= live_nxt;
      lbytes_r <= lbytes_nxt;
      sae_r    <= sae_nxt;
      ras_r    <= ras_nxt;
      ovld_r   <= ovld_nxt;
      pend_r   <= pend_nxt;
      bhave_r  <= bhave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    size_r  <= size_nxt;
    gap_r   <= gap_nxt;
    need_r  <= need_nxt;
    s_r     <= s_nxt;
    app_r   <= app_nxt;
    res_r   <= res_nxt;
    wpos_r  <= wpos_nxt;
    scan_r  <= scan_nxt;
    pidx_r  <= pidx_nxt;
    bslot_r <= bslot_nxt;
    boff_r  <= boff_nxt;
    k_r     <= k_nxt;
    ores_r  <= ores_nxt;
    ofree_r <= ofree_nxt;
    olive_r <= olive_nxt;
  end

  a_live_le_siu: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= siu_r) else $error("live count exceeds slots in use");

  a_siu_max: assert property (@(posedge clk) disable iff (!rst_n)
    siu_r <= MAXS) else $error("slots in use exceeds limit");

  a_take_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (st_r == S_DECODE))
    else $error("command transfer not followed by decode");
endmodule
`default_nettype wire
